@@ rtl/rpmc_pkg.sv @@
// rpmc_pkg: shared constants and types for the randomized prim maze carver
// no dependencies
`default_nettype none
package rpmc_pkg;
	localparam int MAX_HEIGHT = 32;
	localparam int MAX_WIDTH = 32;
	localparam int CELLS = MAX_HEIGHT * MAX_WIDTH;
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int CNT_W = ADDR_W + 1;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic REG_HEIGHT = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [15:0] pick_random;
		logic [15:0] dir_random;
	} req_t;

	typedef struct packed {
		logic carved;
		logic removed;
		logic [6:0] wall_row;
		logic [6:0] wall_col;
		logic [4:0] cell_row;
		logic [4:0] cell_col;
		logic [10:0] frontier_size;
		logic done_res;
	} res_t;
endpackage
`default_nettype wire

@@ rtl/rpmc_if.sv @@
// rpmc_if: valid/ready channel carrying one payload
// the payload type is a parameter; no package dependency
`default_nettype none
interface rpmc_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rpmc_mod.sv @@
// rpmc_mod: iterative remainder unit, one quotient bit a cycle
// depends on rpmc_pkg
`default_nettype none
module rpmc_mod (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] num,
	input  wire logic [10:0] den,
	output logic             busy,
	output logic [10:0]      rem
);
	import rpmc_pkg::*;
	logic [15:0] num_q;
	logic [10:0] rem_q;
	logic [10:0] den_q;
	logic [4:0]  cnt_q;
	logic [11:0] trial;

	assign trial = {rem_q, num_q[15]};
	assign rem = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[14:0], 1'b0};
			rem_q <= (trial >= {1'b0, den_q}) ? 11'(trial - {1'b0, den_q}) : trial[10:0];
		end
	end
endmodule
`default_nettype wire

@@ rtl/rpmc_core.sv @@
// rpmc_core: sequencer over the visited map and frontier list memories
// depends on rpmc_pkg and rpmc_mod
`default_nettype none
module rpmc_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [5:0]     height,
	input  wire logic [5:0]     width,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  rpmc_pkg::req_t      in_req,
	output logic                res_valid,
	input  wire logic           res_ready,
	output rpmc_pkg::res_t      res
);
	import rpmc_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_MOD = 4'd2, S_FRD = 4'd3,
		S_FWT = 4'd4, S_NRD = 4'd5, S_NWT = 4'd6, S_DMOD = 4'd7, S_SHIFT = 4'd8,
		S_OUT = 4'd9;

	logic [3:0] st_q;
	logic vis_mem [CELLS];
	logic [ADDR_W-1:0] fr_mem [CELLS];
	logic vis_rd_q;
	logic [ADDR_W-1:0] fr_rd_q;
	logic [ADDR_W-1:0] vis_ra, fr_ra, vis_wa, fr_wa;
	logic vis_we, vis_wd, fr_we;
	logic [ADDR_W-1:0] fr_wd;

	logic [CNT_W-1:0] cnt_q, idx_q;
	logic [ADDR_W-1:0] clr_q;
	req_t req_q;
	logic [ROW_W-1:0] r_q;
	logic [COL_W-1:0] c_q;
	logic [1:0] dir_q;
	logic [3:0] open_q;
	logic [5:0] h_q, w_q;
	logic mod_start, mod_busy;
	logic [15:0] mod_num;
	logic [10:0] mod_den, mod_rem;
	logic dmod_q;

	logic [2:0] nopen, nopen_nw;
	logic cur_open;
	logic [ROW_W-1:0] br;
	logic [COL_W-1:0] bc;
	logic [1:0] k, kth;
	logic [ROW_W:0] nrow;
	logic [COL_W:0] ncol;

	rpmc_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .num(mod_num),
		.den(mod_den), .busy(mod_busy), .rem(mod_rem)
	);

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd_q <= vis_mem[vis_ra];
	end
	always_ff @(posedge clk) begin
		if (fr_we) fr_mem[fr_wa] <= fr_wd;
		fr_rd_q <= fr_mem[fr_ra];
	end

	assign nopen = {2'b0, open_q[0]} + {2'b0, open_q[1]} + {2'b0, open_q[2]}
		+ {2'b0, open_q[3]};
	assign nopen_nw = nopen + {2'b0, cur_open};
	assign k = mod_rem[1:0];

	always_comb begin
		int n;
		n = 0;
		kth = 2'd0;
		for (int j = 0; j < 4; j++) begin
			if (open_q[j]) begin
				if (n == int'(k)) kth = 2'(j);
				n = n + 1;
			end
		end
	end

	always_comb begin
		br = r_q;
		bc = c_q;
		unique case (kth)
			2'd0: br = r_q - 1'b1;
			2'd1: br = r_q + 1'b1;
			2'd2: bc = c_q - 1'b1;
			2'd3: bc = c_q + 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		nrow = {1'b0, r_q};
		ncol = {1'b0, c_q};
		unique case (dir_q)
			2'd0: nrow = {1'b0, r_q} - 1'b1;
			2'd1: nrow = {1'b0, r_q} + 1'b1;
			2'd2: ncol = {1'b0, c_q} - 1'b1;
			2'd3: ncol = {1'b0, c_q} + 1'b1;
			default: ;
		endcase
	end

	// neighbour in the current direction is inside the grid and unvisited
	always_comb begin
		unique case (dir_q)
			2'd0: cur_open = (r_q != '0) && !vis_rd_q;
			2'd1: cur_open = ({1'b0, nrow} < {1'b0, h_q}) && !vis_rd_q;
			2'd2: cur_open = (c_q != '0) && !vis_rd_q;
			default: cur_open = ({1'b0, ncol} < {1'b0, w_q}) && !vis_rd_q;
		endcase
	end

	assign in_ready = (st_q == S_IDLE) && !res_valid;

	always_comb begin
		vis_ra = {nrow[ROW_W-1:0], ncol[COL_W-1:0]};
		fr_ra = idx_q[ADDR_W-1:0];
		if (st_q == S_SHIFT) fr_ra = ADDR_W'(idx_q + 1'b1);
		vis_we = 1'b0;
		vis_wa = clr_q;
		vis_wd = 1'b0;
		fr_we = 1'b0;
		fr_wa = cnt_q[ADDR_W-1:0];
		fr_wd = {br, bc};
		mod_start = 1'b0;
		mod_num = req_q.pick_random;
		mod_den = cnt_q;
		if (st_q == S_CLR) begin
			vis_we = 1'b1;
			vis_wd = (clr_q == '0);
			fr_we = (clr_q == '0);
			fr_wa = '0;
			fr_wd = '0;
		end
		if (st_q == S_IDLE && in_valid && in_ready && in_req.cmd == CMD_STEP
			&& cnt_q != '0) begin
			mod_start = 1'b1;
			mod_num = in_req.pick_random;
		end
		if (st_q == S_NWT && dir_q == 2'd3) begin
			if (nopen_nw != 3'd0) begin
				mod_start = 1'b1;
				mod_num = req_q.dir_random;
				mod_den = {8'b0, nopen_nw};
			end
		end
		if (st_q == S_DMOD && !mod_busy && !dmod_q) begin
			vis_we = 1'b1;
			vis_wa = {br, bc};
			vis_wd = 1'b1;
			fr_we = (cnt_q < CNT_W'(CELLS));
		end
		if (st_q == S_SHIFT && (idx_q + 1'b1) < cnt_q && dmod_q) begin
			fr_we = 1'b1;
			fr_wa = ADDR_W'(idx_q);
			fr_wd = fr_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			res_valid <= 1'b0;
			res <= '0;
			clr_q <= '0;
			dmod_q <= 1'b0;
			req_q <= '0;
			h_q <= '0;
			w_q <= '0;
			idx_q <= '0;
			r_q <= '0;
			c_q <= '0;
			dir_q <= '0;
			open_q <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid && in_ready) begin
					req_q <= in_req;
					h_q <= (height == 6'd0) ? 6'd1 : (height > 6'(MAX_HEIGHT))
						? 6'(MAX_HEIGHT) : height;
					w_q <= (width == 6'd0) ? 6'd1 : (width > 6'(MAX_WIDTH))
						? 6'(MAX_WIDTH) : width;
					res <= '0;
					if (in_req.cmd == CMD_START) begin
						clr_q <= '0;
						st_q <= S_CLR;
					end else if (cnt_q == '0) begin
						res.done_res <= 1'b1;
						res_valid <= 1'b1;
					end else st_q <= S_MOD;
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						cnt_q <= CNT_W'(1);
						res.frontier_size <= 11'd1;
						res_valid <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				S_MOD: if (!mod_busy) begin
					idx_q <= mod_rem;
					st_q <= S_FRD;
				end
				S_FRD: st_q <= S_FWT;
				S_FWT: begin
					r_q <= fr_rd_q[ADDR_W-1:COL_W];
					c_q <= fr_rd_q[COL_W-1:0];
					dir_q <= 2'd0;
					open_q <= '0;
					st_q <= S_NRD;
				end
				S_NRD: st_q <= S_NWT;
				S_NWT: begin
					open_q[dir_q] <= cur_open;
					if (dir_q == 2'd3) begin
						if (nopen_nw != 3'd0) begin
							dmod_q <= 1'b0;
							st_q <= S_DMOD;
						end else begin
							dmod_q <= 1'b0;
							st_q <= S_SHIFT;
						end
					end else begin
						dir_q <= dir_q + 1'b1;
						st_q <= S_NRD;
					end
				end
				S_DMOD: begin
					if (!mod_busy && !dmod_q) begin
						res.carved <= 1'b1;
						res.wall_row <= 7'(r_q) + 7'(br) + 7'd1;
						res.wall_col <= 7'(c_q) + 7'(bc) + 7'd1;
						res.cell_row <= 5'(br);
						res.cell_col <= 5'(bc);
						if (cnt_q < CNT_W'(CELLS)) begin
							res.frontier_size <= 11'(cnt_q + 1'b1);
							cnt_q <= cnt_q + 1'b1;
						end else res.frontier_size <= 11'(cnt_q);
						res_valid <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				S_SHIFT: begin
					if ((idx_q + 1'b1) >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
						res.removed <= 1'b1;
						res.frontier_size <= 11'(cnt_q - 1'b1);
						res.done_res <= (cnt_q == CNT_W'(1));
						res_valid <= 1'b1;
						st_q <= S_IDLE;
					end else if (!dmod_q) dmod_q <= 1'b1;
					else begin
						dmod_q <= 1'b0;
						idx_q <= idx_q + 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/random_prim_maze_carver_top.sv @@
// random_prim_maze_carver_top: randomized prim maze carver top level
// depends on rpmc_pkg, rpmc_if and rpmc_core
//
// usage: requests arrive on in_ch (cmd, pick_random, dir_random), one result
// leaves on out_ch for each request. height and width are written on the cfg
// port (index 0 height, index 1 width) while the block is idle.
// a start request sweeps the visited map, one cell a cycle.
// a carving step runs a remainder on the frontier count, reads the picked
// entry, reads the four neighbours in turn, then for a carve runs a second
// remainder on the count of open neighbours. removing a dead entry shifts the
// later entries down one place each.
// one request at a time; the result sits in an output register and the next
// request is taken only once it has been delivered. a stalled receiver holds
// the result and blocks new requests.
// reset clears the frontier count and restores height and width to 8; the
// visited map is swept by every start.
`default_nettype none
module random_prim_maze_carver_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [5:0] cfg_wdata,
	rpmc_if.sink            in_ch,
	rpmc_if.source          out_ch
);
	import rpmc_pkg::*;
	logic [5:0] height_q, width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 6'd8;
			width_q <= 6'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEIGHT: height_q <= cfg_wdata;
				REG_WIDTH: width_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rpmc_core u_core (
		.clk(clk), .arst_n(arst_n), .height(height_q), .width(width_q),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.data),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
	);
endmodule
`default_nettype wire
